// ===== rtl/dmps_pkg.sv =====
`default_nettype none

package dmps_pkg;

   localparam int unsigned DUTY_WIDTH    = 8;
   localparam int unsigned COUNT_WIDTH   = 7;
   localparam int unsigned PINS_WIDTH    = 4;
   localparam int unsigned MOTION_WIDTH  = 3;
   localparam int unsigned BYTE_WIDTH    = 8;

   localparam logic [DUTY_WIDTH-1:0]  DUTY_RESET    = 8'd30;
   localparam logic [DUTY_WIDTH-1:0]  DUTY_MIN      = 8'd1;
   localparam logic [DUTY_WIDTH-1:0]  DUTY_MAX      = 8'd99;
   localparam logic [COUNT_WIDTH-1:0] DUTY_FALLBACK = 7'h01;
   localparam logic [COUNT_WIDTH-1:0] PERIOD        = 7'd100;

   localparam logic [PINS_WIDTH-1:0]  PINS_FORWARD  = 4'h5;
   localparam logic [PINS_WIDTH-1:0]  PINS_REVERSE  = 4'hA;
   localparam logic [PINS_WIDTH-1:0]  PINS_OFF      = 4'h0;

   localparam logic [BYTE_WIDTH-1:0]  CMD_FIRST     = 8'h30;
   localparam logic [BYTE_WIDTH-1:0]  CMD_LAST      = 8'h36;

   typedef enum logic {
      KIND_TICK    = 1'b0,
      KIND_COMMAND = 1'b1
   } kind_type;

   typedef enum logic [MOTION_WIDTH-1:0] {
      MOTION_BRAKE         = 3'd0,
      MOTION_FORWARD       = 3'd1,
      MOTION_REVERSE       = 3'd2,
      MOTION_FORWARD_LEFT  = 3'd3,
      MOTION_FORWARD_RIGHT = 3'd4,
      MOTION_REVERSE_LEFT  = 3'd5,
      MOTION_REVERSE_RIGHT = 3'd6
   } motion_type;

endpackage

`default_nettype wire

// ===== rtl/dmps_if.sv =====
`default_nettype none

interface dmps_req_if;
   import dmps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [BYTE_WIDTH-1:0] command_byte;

   modport source (output valid, output mode, output command_byte, input ready);
   modport sink   (input valid, input mode, input command_byte, output ready);
endinterface

interface dmps_rsp_if;
   import dmps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [PINS_WIDTH-1:0]   direction_pins;
   logic                    enable_a;
   logic                    enable_b;
   logic [MOTION_WIDTH-1:0] motion;

   modport source (output valid, output direction_pins, output enable_a, output enable_b,
                   output motion, input ready);
   modport sink   (input valid, input direction_pins, input enable_a, input enable_b,
                   input motion, output ready);
endinterface

`default_nettype wire

// ===== rtl/dual_motor_pwm_steering.sv =====
// Two-motor H-bridge PWM controller.
// The req_if channel carries one beat per event: mode 1 is a received command
// byte, where ASCII '0' through '6' selects brake, forward, reverse, forward-left,
// forward-right, reverse-left or reverse-right and any other byte is ignored;
// mode 0 is one PWM timer tick, which in brake turns the direction pins off and
// otherwise advances the period counter and drives the direction pins and both enables.
// Every request beat yields exactly one beat on rsp_if, showing the pin levels
// and the motion after that event. The result appears in the cycle after the
// request is accepted, and a new request is accepted in every cycle while the
// receiver takes results, so throughput is one beat per cycle.
// When the receiver stalls, the pending result holds and req_if.ready drops
// until it is taken; the state register doubles as the result register.
// The csr_ port writes the duty in percent; values outside 1 to 99 act as 1.
// It should be written only while no result is pending.
// Reset selects brake, clears the counter and all pins, empties the result
// register and sets the duty to 30.
`default_nettype none

module dual_motor_pwm_steering (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [dmps_pkg::DUTY_WIDTH-1:0]  csr_write_data,
   dmps_req_if.sink                              req_if,
   dmps_rsp_if.source                            rsp_if
);
   import dmps_pkg::*;

   logic [DUTY_WIDTH-1:0]  duty_ff;
   motion_type             motion_ff, motion_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [PINS_WIDTH-1:0]  pins_ff, pins_in;
   logic                   enable_a_ff, enable_a_in;
   logic                   enable_b_ff, enable_b_in;
   logic                   rsp_valid_ff;

   logic                   accept;
   logic                   command_known;
   logic [BYTE_WIDTH-1:0]  command_offset;
   logic [COUNT_WIDTH-1:0] duty_eff;
   logic [COUNT_WIDTH-1:0] count_step;
   logic                   inner;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign command_known  = (req_if.command_byte >= CMD_FIRST) &&
                           (req_if.command_byte <= CMD_LAST);
   assign command_offset = req_if.command_byte - CMD_FIRST;

   assign duty_eff   = ((duty_ff >= DUTY_MIN) && (duty_ff <= DUTY_MAX)) ?
                       duty_ff[COUNT_WIDTH-1:0] : DUTY_FALLBACK;
   assign count_step = count_ff + 1'b1;
   assign inner      = count_step <= (duty_eff >> 2);

   always_comb begin
      motion_in   = motion_ff;
      count_in    = count_ff;
      pins_in     = pins_ff;
      enable_a_in = enable_a_ff;
      enable_b_in = enable_b_ff;
      if (kind_type'(req_if.mode) == KIND_COMMAND) begin
         if (command_known) begin
            motion_in = motion_type'(command_offset[MOTION_WIDTH-1:0]);
         end
      end else if (motion_ff == MOTION_BRAKE) begin
         pins_in = PINS_OFF;
      end else begin
         count_in = count_step;
         case (motion_ff) inside
            MOTION_FORWARD, MOTION_FORWARD_LEFT, MOTION_FORWARD_RIGHT: pins_in = PINS_FORWARD;
            default: pins_in = PINS_REVERSE;
         endcase
         if (count_step <= duty_eff) begin
            enable_a_in = 1'b1;
            enable_b_in = 1'b1;
            case (motion_ff) inside
               MOTION_FORWARD_LEFT, MOTION_REVERSE_LEFT:   enable_b_in = inner;
               MOTION_FORWARD_RIGHT, MOTION_REVERSE_RIGHT: enable_a_in = inner;
               default: ;
            endcase
         end else begin
            enable_a_in = 1'b0;
            enable_b_in = 1'b0;
            if (count_step >= PERIOD) begin
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff      <= DUTY_RESET;
         motion_ff    <= MOTION_BRAKE;
         count_ff     <= '0;
         pins_ff      <= PINS_OFF;
         enable_a_ff  <= 1'b0;
         enable_b_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            duty_ff <= csr_write_data;
         end
         if (accept) begin
            motion_ff   <= motion_in;
            count_ff    <= count_in;
            pins_ff     <= pins_in;
            enable_a_ff <= enable_a_in;
            enable_b_ff <= enable_b_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.direction_pins = pins_ff;
   assign rsp_if.enable_a       = enable_a_ff;
   assign rsp_if.enable_b       = enable_b_ff;
   assign rsp_if.motion         = motion_ff;

`ifndef SYNTHESIS
   a_count_in_period: assert property (@(posedge clock) disable iff (reset)
      count_ff <= PERIOD)
      else $error("period counter beyond the period");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_valid_ff)
      else $error("request stalled with no pending result");

   a_command_holds_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.mode == KIND_COMMAND) |=> $stable(count_ff))
      else $error("command beat moved the period counter");

   a_brake_tick_pins_low: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.mode == KIND_TICK && motion_ff == MOTION_BRAKE)
      |=> (pins_ff == PINS_OFF && $stable(count_ff)))
      else $error("brake tick left direction pins driven or moved the counter");
`endif

endmodule

`default_nettype wire
